### hw/rtl/nvt_pkg.sv
// Shared types and constants for the named value table.
package nvt_pkg;

  // Item actions
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_DEFINE = 2'd1,
    ACT_UNDEF  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RESERVED  = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Reserved names and their built-in double patterns
  localparam logic [63:0] KEY_PI = 64'h0000_0000_0000_6970;
  localparam logic [63:0] KEY_E  = 64'h0000_0000_0000_0065;
  localparam logic [63:0] VAL_PI = 64'h4009_21FB_5444_2D18;
  localparam logic [63:0] VAL_E  = 64'h4005_BF0A_8B14_5769;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic wr;     // load write data into this cell
    logic vld;    // valid mark to load on a write
  } cell_ctrl_t;

endpackage

### hw/rtl/named_value_table.sv
// Named value table: a rotating ring of entry cells driven by a scan sequencer.
// Items are accepted only in the idle state; each item then takes a full rotation
// of the cell ring past the compare point at cell 0, then a done step that updates
// the table and loads the result, held while an earlier result is not yet taken.
// The result register lets the next item be taken while a result waits.
// Reset (async, active low) clears all valid marks and the control state.
module named_value_table #(
  parameter int ENTRIES    = 32,
  parameter int NAME_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] result_value_o
);
  import nvt_pkg::*;

  localparam int KEY_W = 8 * NAME_BYTES;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  action_e          act_q;
  logic [KEY_W-1:0] key_q;
  logic [63:0]      val_q;
  logic             hit_q, hit_d, free_q, free_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [63:0]      hit_val_q, hit_val_d;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [63:0]      res_q, res_d;

  logic             accept;
  logic [KEY_W-1:0] norm_key;
  logic             keep;
  logic             done_go;
  logic             rsv;
  logic             do_wr;
  logic             wr_vld;
  logic [IDX_W-1:0] wr_idx;
  logic [ENTRIES-1:0] wr_vec;

  cell_ctrl_t       ctrl [ENTRIES];
  logic             c_vld [ENTRIES];
  logic [KEY_W-1:0] c_key [ENTRIES];
  logic [63:0]      c_val [ENTRIES];

  // Name ends at its first zero byte
  always_comb begin
    keep = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (key_i[b*8 +: 8] == 8'd0) begin
        keep = 1'b0;
      end
      norm_key[b*8 +: 8] = keep ? key_i[b*8 +: 8] : 8'd0;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign done_go    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign rsv        = (64'(key_q) == KEY_PI) || (64'(key_q) == KEY_E);

  // Scan at cell 0: lowest match and lowest free slot
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_val_d  = hit_val_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (c_vld[0] && (c_key[0] == key_q) && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = cnt_q;
          hit_val_d = c_val[0];
        end
        if (!c_vld[0] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = cnt_q;
        end
        if (cnt_q == LAST_IDX) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (done_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result and table update decision
  always_comb begin
    status_d = ST_OK;
    res_d    = '0;
    do_wr    = 1'b0;
    wr_vld   = 1'b1;
    wr_idx   = hit_q ? hit_idx_q : free_idx_q;
    case (act_q)
      ACT_LOOKUP: begin
        if (64'(key_q) == KEY_PI) begin
          res_d = VAL_PI;
        end else if (64'(key_q) == KEY_E) begin
          res_d = VAL_E;
        end else if (hit_q) begin
          res_d = hit_val_q;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      ACT_DEFINE: begin
        if (rsv) begin
          status_d = ST_RESERVED;
        end else if (hit_q || free_q) begin
          do_wr = 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      ACT_UNDEF: begin
        wr_vld = 1'b0;
        if (rsv) begin
          status_d = ST_RESERVED;
        end else if (hit_q) begin
          do_wr = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(action_i);
      key_q <= norm_key;
      val_q <= value_i;
    end
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
    if (done_go) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  // Ring of cells; cell i takes from cell i+1
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign wr_vec[i]     = done_go && do_wr && (wr_idx == IDX_W'(i));
    assign ctrl[i].shift = (state_q == S_SCAN);
    assign ctrl[i].wr    = wr_vec[i];
    assign ctrl[i].vld   = wr_vld;

    nvt_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[i]),
      .nb_vld_i  (c_vld[(i + 1) % ENTRIES]),
      .nb_key_i  (c_key[(i + 1) % ENTRIES]),
      .nb_value_i(c_val[(i + 1) % ENTRIES]),
      .wr_key_i  (key_q),
      .wr_value_i(val_q),
      .vld_o     (c_vld[i]),
      .key_o     (c_key[i]),
      .value_o   (c_val[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = res_q;

`ifndef SYNTH
  // Sequencer state stays one-hot
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  // At most one cell is written per cycle
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_vec))
    else $error("multiple cell writes");

  // Scan counter advances by one per rotation step
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (cnt_q != LAST_IDX) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("scan counter skipped");

  // A result is loaded only after a full scan
  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_DONE) |-> $past(cnt_q) == LAST_IDX)
    else $error("scan ended early");
`endif

endmodule

### hw/rtl/nvt_cell.sv
// One table cell: holds an entry and passes it to its neighbor in the ring.
module nvt_cell #(
  parameter int KEY_W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nvt_pkg::cell_ctrl_t ctrl_i,
  input  logic               nb_vld_i,
  input  logic [KEY_W-1:0]   nb_key_i,
  input  logic [63:0]        nb_value_i,
  input  logic [KEY_W-1:0]   wr_key_i,
  input  logic [63:0]        wr_value_i,
  output logic               vld_o,
  output logic [KEY_W-1:0]   key_o,
  output logic [63:0]        value_o
);
  import nvt_pkg::*;

  logic             vld_q, vld_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [63:0]      value_q, value_d;

  // Next entry: rotate from neighbor, or load from the sequencer
  always_comb begin
    vld_d   = vld_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      vld_d   = nb_vld_i;
      key_d   = nb_key_i;
      value_d = nb_value_i;
    end else if (ctrl_i.wr) begin
      vld_d   = ctrl_i.vld;
      key_d   = wr_key_i;
      value_d = wr_value_i;
    end
  end

  // Valid mark is cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Key and value hold no reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign vld_o   = vld_q;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule
